// ===== rtl/fbpb_pkg.sv =====
// Shared package for the framebuffer pixel blend writer.
// Holds frame geometry defaults, command and register codes, and pixel helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbpb_pkg;

  // Default frame geometry
  localparam int unsigned FrameWidthDef  = 320;
  localparam int unsigned FrameHeightDef = 240;

  // Fixed field widths
  localparam int unsigned CoordInW = 12;
  localparam int unsigned WinXW    = 9;
  localparam int unsigned WinYW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  // Item commands
  typedef enum logic [1:0] {
    CmdWrite = 2'd0,
    CmdBlend = 2'd1,
    CmdRead  = 2'd2
  } cmd_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgWinX   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWinY   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCorner = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgAxis   = 2'd3;

  // Origin corners
  localparam logic [1:0] Corner0 = 2'd0;
  localparam logic [1:0] Corner1 = 2'd1;
  localparam logic [1:0] Corner2 = 2'd2;
  localparam logic [1:0] Corner3 = 2'd3;

  // Expand RGB565 to RGB888 by shifting
  function automatic logic [23:0] expand565(input logic [15:0] p);
    expand565 = {p[15:11], 3'b000, p[10:5], 2'b00, p[4:0], 3'b000};
  endfunction

  // Mix one channel: (a*fg + (256-a)*bg) >> 8
  function automatic logic [7:0] mix8(input logic [7:0] a, input logic [7:0] fg,
                                      input logic [7:0] bg);
    logic [8:0]  inv;
    logic [16:0] acc;
    inv = 9'd256 - {1'b0, a};
    acc = {9'd0, a} * {9'd0, fg} + {8'd0, inv} * {9'd0, bg};
    mix8 = acc[15:8];
  endfunction

  // Blend an RGB888 color into a stored RGB565 pixel, return RGB565
  function automatic logic [15:0] blend565(input logic [15:0] bg565,
                                           input logic [23:0] fg, input logic [7:0] a);
    logic [23:0] bg;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    bg = expand565(bg565);
    r = mix8(a, fg[23:16], bg[23:16]);
    g = mix8(a, fg[15:8], bg[15:8]);
    b = mix8(a, fg[7:0], bg[7:0]);
    blend565 = {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/framebuffer_pixel_blend_writer_core.sv =====
// Top level of the framebuffer pixel blend writer: configuration registers,
// item sequencer and result register. Uses fbpb_pkg, fbpb_addr, fbpb_store.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command per
//   transaction: write an RGB565 pixel, blend an RGB888 color with alpha, or
//   read a pixel at signed (x_i, y_i). Output channel (out_valid_o /
//   out_stall_i) returns one result per command: status_o flags an address
//   outside the store; pixel fields carry the pixel on a read, else zero.
//   Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i);
//   it is to be written only while no command is in flight; the block does
//   not enforce this. Each command passes the states StLoc1, StLoc2, StRead
//   and StDone, the two-stage address unit, the registered RAM read and the
//   modify/write-back step on the single RAM port pair before its result is
//   registered; one command is in flight at a time.
//   Reset: control registers return to defaults and the frame store is swept
//   to zero, one pixel per cycle, over all FrameWidth*FrameHeight pixels
//   (76800 by default); in_stall_o stays high during the sweep.
//   Receiver stall: a finished result waits in the output register; the next
//   command is still taken and worked up to its write-back, which waits
//   until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module framebuffer_pixel_blend_writer_core #(
  parameter int unsigned FrameWidth  = fbpb_pkg::FrameWidthDef,
  parameter int unsigned FrameHeight = fbpb_pkg::FrameHeightDef
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire logic [fbpb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [fbpb_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [fbpb_pkg::CoordInW-1:0] x_i,
  input  wire logic [fbpb_pkg::CoordInW-1:0] y_i,
  input  wire logic [23:0]                   color_i,
  input  wire logic [7:0]                    alpha_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic                               status_o,
  output logic [15:0]                        pixel_rgb565_o,
  output logic [23:0]                        pixel_rgb888_o
);
  import fbpb_pkg::*;

  localparam int unsigned Depth = FrameWidth * FrameHeight;
  localparam int unsigned AddrW = $clog2(Depth);

  typedef enum logic [2:0] {
    StIdle,
    StLoc1,
    StLoc2,
    StRead,
    StDone
  } state_e;

  state_e             state_q;
  logic [WinXW-1:0]   win_x_q;
  logic [WinYW-1:0]   win_y_q;
  logic [1:0]         corner_q;
  logic               axis_q;
  logic [1:0]         cmd_q;
  logic [CoordInW-1:0] x_q, y_q;
  logic [23:0]        color_q;
  logic [7:0]         alpha_q;

  logic               loc_ok;
  logic [AddrW-1:0]   loc_addr;
  logic [15:0]        rd_data;
  logic               store_ready;
  logic               in_fire;
  logic               done_fire;
  logic               is_write, is_blend, is_read;
  logic               rd_en;
  logic               wr_en;
  logic [15:0]        wr_data;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_x_q  <= '0;
      win_y_q  <= '0;
      corner_q <= Corner0;
      axis_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgWinX:   win_x_q  <= cfg_data_i;
        CfgWinY:   win_y_q  <= cfg_data_i[WinYW-1:0];
        CfgCorner: corner_q <= cfg_data_i[1:0];
        CfgAxis:   axis_q   <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  fbpb_addr #(
    .FrameWidth (FrameWidth),
    .FrameHeight(FrameHeight),
    .AddrW      (AddrW)
  ) u_addr (
    .clk_i   (clk_i),
    .x_i     (x_q),
    .y_i     (y_q),
    .win_x_i (win_x_q),
    .win_y_i (win_y_q),
    .corner_i(corner_q),
    .axis_i  (axis_q),
    .ok_o    (loc_ok),
    .addr_o  (loc_addr)
  );

  fbpb_store #(
    .Depth(Depth),
    .AddrW(AddrW)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(loc_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(loc_addr),
    .wr_data_i(wr_data),
    .ready_o  (store_ready)
  );

  // Command decode
  assign is_write = (cmd_q == CmdWrite);
  assign is_blend = (cmd_q == CmdBlend);
  assign is_read  = (cmd_q == CmdRead);

  // Handshakes
  assign in_stall_o = !(state_q == StIdle && store_ready);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign done_fire  = (state_q == StDone) && (!out_valid_o || !out_stall_i);

  // Read, modify, write back
  assign rd_en   = (state_q == StRead) && loc_ok;
  assign wr_en   = done_fire && loc_ok && (is_write || is_blend);
  assign wr_data = is_write ? color_q[15:0] : blend565(rd_data, color_q, alpha_q);

  // Item capture, sequencing and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_o <= 1'b0;
    end else begin
      // Load a new result or drop the accepted one
      if (done_fire) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            state_q <= StLoc1;
          end
        end
        StLoc1: state_q <= StLoc2;
        StLoc2: state_q <= StRead;
        StRead: state_q <= StDone;
        StDone: begin
          if (done_fire) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= cmd_i;
      x_q     <= x_i;
      y_q     <= y_i;
      color_q <= color_i;
      alpha_q <= alpha_i;
    end
    if (done_fire) begin
      status_o <= !loc_ok && (is_write || is_blend || is_read);
      if (loc_ok && is_read) begin
        pixel_rgb565_o <= rd_data;
        pixel_rgb888_o <= expand565(rd_data);
      end else begin
        pixel_rgb565_o <= '0;
        pixel_rgb888_o <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fbpb_addr.sv =====
// Two-stage address unit: orientation remap and window offset, then
// linear index and range check. Depends on fbpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbpb_addr #(
  parameter int unsigned FrameWidth  = fbpb_pkg::FrameWidthDef,
  parameter int unsigned FrameHeight = fbpb_pkg::FrameHeightDef,
  parameter int unsigned AddrW       = $clog2(FrameWidth * FrameHeight)
) (
  input  wire                               clk_i,
  input  wire logic [fbpb_pkg::CoordInW-1:0] x_i,
  input  wire logic [fbpb_pkg::CoordInW-1:0] y_i,
  input  wire logic [fbpb_pkg::WinXW-1:0]    win_x_i,
  input  wire logic [fbpb_pkg::WinYW-1:0]    win_y_i,
  input  wire logic [1:0]                    corner_i,
  input  wire logic                          axis_i,
  output logic                               ok_o,
  output logic [AddrW-1:0]                   addr_o
);
  import fbpb_pkg::*;

  localparam int unsigned MaxDim = (FrameWidth > FrameHeight) ? FrameWidth : FrameHeight;
  localparam int unsigned CoordW = $clog2(MaxDim + 2048 + 512 + 1) + 1;
  localparam int unsigned IdxW   = CoordW + $clog2(FrameWidth + 1) + 1;
  localparam logic [CoordW-1:0] WidthC  = CoordW'(FrameWidth);
  localparam logic [CoordW-1:0] HeightC = CoordW'(FrameHeight);
  localparam logic [IdxW-1:0]   WidthI  = IdxW'(FrameWidth);
  localparam logic [IdxW-1:0]   DepthI  = IdxW'(FrameWidth * FrameHeight);

  logic [CoordW-1:0] xe, ye, ax, ay, col, row;
  logic [CoordW-1:0] col_q, row_q;
  logic [IdxW-1:0]   idx;

  // Remap coordinates by origin corner and axis order
  always_comb begin
    xe = {{(CoordW-CoordInW){x_i[CoordInW-1]}}, x_i};
    ye = {{(CoordW-CoordInW){y_i[CoordInW-1]}}, y_i};
    ax = WidthC - xe;
    ay = HeightC - ye;
    case (corner_i)
      Corner0: begin
        col = axis_i ? xe : ye;
        row = axis_i ? ye : xe;
      end
      Corner1: begin
        col = axis_i ? ay : xe;
        row = axis_i ? xe : ay;
      end
      Corner2: begin
        col = axis_i ? ay : ax;
        row = axis_i ? ax : ay;
      end
      default: begin
        col = axis_i ? ax : ye;
        row = axis_i ? ye : ax;
      end
    endcase
  end

  // Stage 1: add window origin
  always_ff @(posedge clk_i) begin
    col_q <= col + {{(CoordW-WinXW){1'b0}}, win_x_i};
    row_q <= row + {{(CoordW-WinYW){1'b0}}, win_y_i};
  end

  // Linear index in two's complement
  assign idx = {{(IdxW-CoordW){row_q[CoordW-1]}}, row_q} * WidthI
             + {{(IdxW-CoordW){col_q[CoordW-1]}}, col_q};

  // Stage 2: range check and address
  always_ff @(posedge clk_i) begin
    ok_o   <= !idx[IdxW-1] && (idx < DepthI);
    addr_o <= idx[AddrW-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/fbpb_store.sv =====
// Frame store: one synchronous RAM with registered read and a clearing
// sweep after reset. Depends on fbpb_pkg for defaults.
`timescale 1ns / 1ps
`default_nettype none

module fbpb_store #(
  parameter int unsigned Depth = fbpb_pkg::FrameWidthDef * fbpb_pkg::FrameHeightDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              rd_en_i,
  input  wire [AddrW-1:0]  rd_addr_i,
  output logic [15:0]      rd_data_o,
  input  wire              wr_en_i,
  input  wire [AddrW-1:0]  wr_addr_i,
  input  wire [15:0]       wr_data_i,
  output logic             ready_o
);
  import fbpb_pkg::*;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  logic [15:0]      mem [Depth];
  logic             clearing_q;
  logic [AddrW-1:0] clr_addr_q;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [15:0]      wdata;

  // Sweep every entry to zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      if (clr_addr_q == LastAddr) begin
        clearing_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  assign ready_o = !clearing_q;
  assign we      = clearing_q || wr_en_i;
  assign waddr   = clearing_q ? clr_addr_q : wr_addr_i;
  assign wdata   = clearing_q ? 16'h0000 : wr_data_i;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fbpb_checker.sv =====
// Port-level checker for the framebuffer pixel blend writer, bound to the
// top level. Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module fbpb_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire        status_o,
  input wire [15:0] pixel_rgb565_o,
  input wire [23:0] pixel_rgb888_o
);

  // Held result keeps valid up while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // One command in flight: the port closes right after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second command taken while one is in flight");

  // Out-of-area result carries no pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> pixel_rgb565_o == 16'h0000 && pixel_rgb888_o == 24'h0)
    else $error("pixel data on out-of-area result");

  // RGB888 field is the shifted expansion of the RGB565 field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pixel_rgb888_o[23:19] == pixel_rgb565_o[15:11]
      && pixel_rgb888_o[15:10] == pixel_rgb565_o[10:5]
      && pixel_rgb888_o[7:3] == pixel_rgb565_o[4:0]
      && pixel_rgb888_o[18:16] == 3'b000 && pixel_rgb888_o[9:8] == 2'b00
      && pixel_rgb888_o[2:0] == 3'b000)
    else $error("RGB888 expansion mismatch");

endmodule

bind framebuffer_pixel_blend_writer_core fbpb_checker u_fbpb_checker (.*);

`default_nettype wire
